// File: rtl/rtrb_pkg.sv
// Shared types and codes for the trace record ring buffer.
package rtrb_pkg;

  typedef enum logic [1:0] {
    REQ_HEADER = 2'd0,
    REQ_VALUE  = 2'd1,
    REQ_SEND   = 2'd2,
    REQ_FLUSH  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_EMPTY   = 3'd0,
    ST_SENT    = 3'd1,
    ST_BUSY    = 3'd2,
    ST_HEADER  = 3'd3,
    ST_DROP    = 3'd4,
    ST_VALUE   = 3'd5,
    ST_FLUSHED = 3'd6
  } status_e;

  // Classified request as queued between front and back.
  typedef struct packed {
    req_e        op;
    logic [31:0] word_a;  // reference word for a header, value word otherwise
    logic [31:0] word_b;  // timestamp
    logic [7:0]  count;
    logic        busy;
  } cmd_t;

endpackage

// File: rtl/rtrb_if.sv
// Request and response channel interfaces of the trace record ring buffer.
interface rtrb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] ref_word;
  logic [31:0] stamp;
  logic [7:0]  value_count;
  logic [31:0] value_word;
  logic        monitor_busy;

  modport source (
    output valid, req_type, ref_word, stamp, value_count, value_word, monitor_busy,
    input  ready
  );
  modport sink (
    input  valid, req_type, ref_word, stamp, value_count, value_word, monitor_busy,
    output ready
  );
endinterface

interface rtrb_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] out_word;
  logic        record_done;
  logic [8:0]  free_words;

  modport source (
    output valid, status, out_word, record_done, free_words,
    input  ready
  );
  modport sink (
    input  valid, status, out_word, record_done, free_words,
    output ready
  );
endinterface

// File: rtl/rtrb_front.sv
// Request front end: accept, classify and queue requests for the back end.
module rtrb_front
  import rtrb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rtrb_req_if.sink    req_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_ready_i
);

  cmd_t       slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  cmd_t       cmd_in;

  assign req_i.ready = (cnt_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = slot_q[rd_q];

  always_comb begin
    cmd_in.op     = req_e'(req_i.req_type);
    cmd_in.word_a = (req_e'(req_i.req_type) == REQ_HEADER) ? req_i.ref_word
                                                             : req_i.value_word;
    cmd_in.word_b = req_i.stamp;
    cmd_in.count  = req_i.value_count;
    cmd_in.busy   = req_i.monitor_busy;
  end

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= cmd_in;
    end
  end

endmodule

// File: rtl/rtrb_back.sv
// Request back end: ring storage, pointers and response register.
module rtrb_back
  import rtrb_pkg::*;
#(
  parameter int RING_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_ready_o,
  rtrb_rsp_if.source  rsp_o
);

  localparam int PW = $clog2(2 * RING_DEPTH);
  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = (PW > 9) ? PW : 9;
  localparam int TW = ((PW > 8) ? PW : 8) + 1;
  localparam logic [PW-1:0] PtrLast = PW'(2 * RING_DEPTH - 1);
  localparam logic [PW-1:0] DepthP  = PW'(RING_DEPTH);
  localparam logic [PW:0]   SpanW   = (PW + 1)'(2 * RING_DEPTH);
  localparam logic [TW-1:0] DepthT  = TW'(RING_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HDR2,
    S_REPORT
  } state_e;

  function automatic logic [PW-1:0] ptr_nxt(input logic [PW-1:0] p);
    return (p == PtrLast) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_idx(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p >= DepthP) ? p - DepthP : p;
    return r[AW-1:0];
  endfunction

  function automatic logic [PW-1:0] ptr_dist(input logic [PW-1:0] a,
                                             input logic [PW-1:0] b);
    logic [PW:0] t;
    t = (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + SpanW - {1'b0, b});
    return t[PW-1:0];
  endfunction

  logic [31:0]   mem [RING_DEPTH];
  logic [31:0]   rd_data_q;
  logic          mem_we, rd_en;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  state_e        state_q, state_d;
  logic [PW-1:0] commit_q, commit_d;
  logic [PW-1:0] tail_q, tail_d;
  logic [PW-1:0] wptr_q, wptr_d;
  logic [7:0]    left_q, left_d;
  logic          open_q, open_d;
  status_e       pend_status_q, pend_status_d;
  logic          pend_done_q, pend_done_d;
  logic          out_valid_q, out_valid_d;
  status_e       out_status_q, out_status_d;
  logic [31:0]   out_word_q, out_word_d;
  logic          out_done_q, out_done_d;
  logic [8:0]    out_free_q, out_free_d;

  logic [PW-1:0] room;
  logic [8:0]    need;
  logic          room_ok;
  logic [TW-1:0] taken, taken_sat, free_full;

  assign room    = DepthP - ptr_dist(commit_q, tail_q);
  assign need    = {1'b0, cmd_i.count} + 9'd2;
  assign room_ok = CW'(room) >= CW'(need);

  assign taken     = TW'(ptr_dist(wptr_q, tail_q)) + TW'(left_q);
  assign taken_sat = (taken > DepthT) ? DepthT : taken;
  assign free_full = DepthT - taken_sat;

  always_comb begin
    state_d       = state_q;
    commit_d      = commit_q;
    tail_d        = tail_q;
    wptr_d        = wptr_q;
    left_d        = left_q;
    open_d        = open_q;
    pend_status_d = pend_status_q;
    pend_done_d   = pend_done_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;
    out_status_d  = out_status_q;
    out_word_d    = out_word_q;
    out_done_d    = out_done_q;
    out_free_d    = out_free_q;
    mem_we        = 1'b0;
    mem_waddr     = ptr_idx(wptr_q);
    mem_wdata     = cmd_i.word_a;
    rd_en         = 1'b0;
    cmd_ready_o   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          pend_status_d = ST_DROP;
          pend_done_d   = 1'b0;
          state_d       = S_REPORT;
          case (cmd_i.op)
            REQ_HEADER: begin
              // abandon any unfinished record
              wptr_d = commit_q;
              left_d = 8'd0;
              open_d = 1'b0;
              if (room_ok) begin
                // write the reference word now, keep the request for the stamp
                mem_we    = 1'b1;
                mem_waddr = ptr_idx(commit_q);
                wptr_d    = ptr_nxt(commit_q);
                state_d   = S_HDR2;
              end else begin
                cmd_ready_o = 1'b1;
              end
            end
            REQ_VALUE: begin
              cmd_ready_o = 1'b1;
              if (open_q && left_q != 8'd0) begin
                mem_we        = 1'b1;
                wptr_d        = ptr_nxt(wptr_q);
                left_d        = left_q - 8'd1;
                pend_status_d = ST_VALUE;
                if (left_q == 8'd1) begin
                  commit_d    = ptr_nxt(wptr_q);
                  open_d      = 1'b0;
                  pend_done_d = 1'b1;
                end
              end
            end
            REQ_SEND: begin
              cmd_ready_o = 1'b1;
              if (commit_q == tail_q) begin
                pend_status_d = ST_EMPTY;
              end else if (cmd_i.busy) begin
                pend_status_d = ST_BUSY;
              end else begin
                rd_en         = 1'b1;
                tail_d        = ptr_nxt(tail_q);
                pend_status_d = ST_SENT;
              end
            end
            REQ_FLUSH: begin
              cmd_ready_o   = 1'b1;
              tail_d        = commit_q;
              pend_status_d = ST_FLUSHED;
            end
            default: begin
              cmd_ready_o = 1'b1;
            end
          endcase
        end
      end
      S_HDR2: begin
        cmd_ready_o   = 1'b1;
        mem_we        = 1'b1;
        mem_wdata     = cmd_i.word_b;
        wptr_d        = ptr_nxt(wptr_q);
        pend_status_d = ST_HEADER;
        if (cmd_i.count == 8'd0) begin
          commit_d    = ptr_nxt(wptr_q);
          pend_done_d = 1'b1;
        end else begin
          left_d = cmd_i.count;
          open_d = 1'b1;
        end
        state_d = S_REPORT;
      end
      S_REPORT: begin
        // hold here until the response register frees up
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = pend_status_q;
          out_word_d   = (pend_status_q == ST_SENT) ? rd_data_q : 32'd0;
          out_done_d   = pend_done_q;
          out_free_d   = free_full[8:0];
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      commit_q      <= '0;
      tail_q        <= '0;
      wptr_q        <= '0;
      left_q        <= 8'd0;
      open_q        <= 1'b0;
      pend_status_q <= ST_DROP;
      pend_done_q   <= 1'b0;
      out_valid_q   <= 1'b0;
      out_status_q  <= ST_EMPTY;
      out_word_q    <= 32'd0;
      out_done_q    <= 1'b0;
      out_free_q    <= 9'd0;
    end else begin
      state_q       <= state_d;
      commit_q      <= commit_d;
      tail_q        <= tail_d;
      wptr_q        <= wptr_d;
      left_q        <= left_d;
      open_q        <= open_d;
      pend_status_q <= pend_status_d;
      pend_done_q   <= pend_done_d;
      out_valid_q   <= out_valid_d;
      out_status_q  <= out_status_d;
      out_word_q    <= out_word_d;
      out_done_q    <= out_done_d;
      out_free_q    <= out_free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem[ptr_idx(tail_q)];
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.out_word    = out_word_q;
  assign rsp_o.record_done = out_done_q;
  assign rsp_o.free_words  = out_free_q;

endmodule

// File: rtl/trace_record_ring_buffer_unit.sv
// Top level of the trace record ring buffer.
//
// Request channel req_i carries one request per transfer: a record header
// (reference word, timestamp, value count), a record value, a try-send of
// one word to the monitor port, or a flush. Response channel rsp_o returns
// exactly one response per request, in request order: status, sent word,
// record-complete flag and free ring words after the request.
// Requests go into a two-entry queue; the back end takes them one at a time.
// Value, flush and send pass through the back end's idle and report states;
// a header with room also passes through a second header state (two ring
// writes through the single write port). The back end takes no new request
// until the last one's response is loaded into the response register.
// Reset clears the pointers, the open record, the request queue and the
// response register; ring contents are not cleared and no clearing pass runs.
// When the receiver stalls, the response register holds, the back end waits
// with its finished result, and the request queue fills and then drops ready.
module trace_record_ring_buffer_unit
  import rtrb_pkg::*;
#(
  parameter int RING_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rtrb_req_if.sink   req_i,
  rtrb_rsp_if.source rsp_o
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  rtrb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  rtrb_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .rsp_o       (rsp_o)
  );

  // only a sent word may carry data
  a_word_only_when_sent: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != ST_SENT) |-> (rsp_o.out_word == 32'd0)
  ) else $error("out_word nonzero on a response that sent nothing");

  // a record completes only on an accepted header or a stored value
  a_done_status: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.record_done) |->
      (rsp_o.status == ST_HEADER || rsp_o.status == ST_VALUE)
  ) else $error("record_done with a status that cannot commit a record");

  // the back end never pops a request the queue does not hold
  a_pop_has_data: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd_ready |-> cmd_valid
  ) else $error("back end consumed a request from an empty queue");

endmodule
